>>> rtl/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg: shared types for the CSR sparse matrix-vector block
// Payload structs, input command codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package csm_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD_NZ  = 2'd0,
    CMD_LOAD_END = 2'd1,
    CMD_LOAD_VEC = 2'd2,
    CMD_RUN      = 2'd3
  } csm_cmd_e;

  typedef struct packed {
    csm_cmd_e           cmd;
    logic [9:0]         slot;
    logic signed [31:0] value;
    logic [5:0]         column;
    logic [10:0]        row_end;
  } csm_in_t;

  typedef struct packed {
    logic [5:0]         row;
    logic signed [63:0] dot;
    logic               last;
  } csm_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW_RD,
    ST_STREAM,
    ST_DRAIN,
    ST_EMIT
  } csm_state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // input transfer this cycle
    logic run_start;  // reset row and start pointers
    logic end_rd;     // read row end, load k, clear accumulator
    logic issue;      // read nonzero k, advance k
    logic emit;       // load result register
    logic next_row;   // advance to the next row
  } csm_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic k_lt_end;
    logic pipe_empty;
    logic last_row;
    logic rows_zero;
    logic out_free;
  } csm_stat_t;

endpackage

>>> rtl/csm_ctrl.sv
// ----------------------------------------------------------------------------
// csm_ctrl: run sequencer
// Accepts load and run items, then steps a run row by row: fetch the row
// end, stream the row's nonzeros, drain the pipeline, emit the result.
// ----------------------------------------------------------------------------
module csm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  csm_pkg::csm_cmd_e   in_cmd_i,
  output logic                in_stall_o,
  input  csm_pkg::csm_stat_t  stat_i,
  output csm_pkg::csm_ctl_t   ctl_o
);
  import csm_pkg::*;

  csm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        ctl_o.accept = in_valid_i;
        if (in_valid_i && in_cmd_i == CMD_RUN && !stat_i.rows_zero) begin
          ctl_o.run_start = 1'b1;
          state_d         = ST_ROW_RD;
        end
      end
      ST_ROW_RD: begin
        ctl_o.end_rd = 1'b1;
        state_d      = ST_STREAM;
      end
      ST_STREAM: begin
        if (stat_i.k_lt_end) begin
          ctl_o.issue = 1'b1;
        end else begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat_i.pipe_empty) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold until the result register can take the row
        if (stat_i.out_free) begin
          ctl_o.emit = 1'b1;
          if (stat_i.last_row) begin
            state_d = ST_IDLE;
          end else begin
            ctl_o.next_row = 1'b1;
            state_d        = ST_ROW_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/csm_datapath.sv
// ----------------------------------------------------------------------------
// csm_datapath: stores, pointers and multiply-accumulate pipeline
// Holds the nonzero, row end and vector memories, the row_count register,
// a four-stage read/read/multiply/accumulate pipe and the result register.
// ----------------------------------------------------------------------------
module csm_datapath #(
  parameter int MAX_NONZEROS = 1024,
  parameter int MAX_ROWS     = 64,
  parameter int COLS         = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_data_i,
  input  csm_pkg::csm_in_t    in_data_i,
  input  csm_pkg::csm_ctl_t   ctl_i,
  output csm_pkg::csm_stat_t  stat_o,
  output logic                out_valid_o,
  output csm_pkg::csm_out_t   out_data_o,
  input  logic                out_stall_i
);
  import csm_pkg::*;

  localparam int NZ_AW = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
  localparam int PTR_W = $clog2(MAX_NONZEROS + 1);
  localparam int RA_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int VA_W  = (COLS > 1) ? $clog2(COLS) : 1;

  logic [31:0]      nz_val_mem [MAX_NONZEROS];
  logic [5:0]       nz_col_mem [MAX_NONZEROS];
  logic [PTR_W-1:0] end_mem    [MAX_ROWS];
  logic [31:0]      vec_mem    [COLS];

  logic [6:0]       row_count_q;
  logic [6:0]       rows;
  logic [6:0]       row_q;
  logic [PTR_W-1:0] start_q, k_q, ends_rd_q;

  logic               v1_q, v2_q, v3_q;
  logic signed [31:0] nz_val_rd_q, val2_q, vec_rd_q;
  logic [5:0]         nz_col_rd_q;
  logic               col_ok;
  logic signed [63:0] prod_q, acc_q, acc_d;
  logic signed [64:0] sum;

  logic               out_valid_q;
  csm_out_t           out_q;

  logic nz_we, end_we, vec_we;
  logic [PTR_W-1:0] end_clamped;

  // load decode
  always_comb begin
    nz_we  = ctl_i.accept && in_data_i.cmd == CMD_LOAD_NZ &&
             32'(in_data_i.slot) < MAX_NONZEROS;
    end_we = ctl_i.accept && in_data_i.cmd == CMD_LOAD_END &&
             32'(in_data_i.slot) < MAX_ROWS;
    vec_we = ctl_i.accept && in_data_i.cmd == CMD_LOAD_VEC &&
             32'(in_data_i.slot) < COLS;
    // clamp on write: the stored end is only ever used clamped
    end_clamped = (32'(in_data_i.row_end) > MAX_NONZEROS) ?
                  PTR_W'(MAX_NONZEROS) : PTR_W'(in_data_i.row_end);
  end

  always_ff @(posedge clk_i) begin
    if (nz_we) begin
      nz_val_mem[NZ_AW'(in_data_i.slot)] <= in_data_i.value;
      nz_col_mem[NZ_AW'(in_data_i.slot)] <= in_data_i.column;
    end
    if (ctl_i.issue) begin
      nz_val_rd_q <= nz_val_mem[k_q[NZ_AW-1:0]];
      nz_col_rd_q <= nz_col_mem[k_q[NZ_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_we) begin
      end_mem[RA_W'(in_data_i.slot)] <= end_clamped;
    end
    if (ctl_i.end_rd) begin
      ends_rd_q <= end_mem[RA_W'(row_q)];
    end
  end

  assign col_ok = 32'(nz_col_rd_q) < COLS;

  always_ff @(posedge clk_i) begin
    if (vec_we) begin
      vec_mem[VA_W'(in_data_i.slot)] <= in_data_i.value;
    end
    if (v1_q && col_ok) begin
      vec_rd_q <= vec_mem[VA_W'(nz_col_rd_q)];
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    val2_q <= nz_val_rd_q;
    prod_q <= val2_q * vec_rd_q;
    acc_q  <= acc_d;
  end

  // saturating accumulate
  always_comb begin
    sum   = {acc_q[63], acc_q} + {prod_q[63], prod_q};
    acc_d = acc_q;
    if (ctl_i.end_rd) begin
      acc_d = '0;
    end else if (v3_q) begin
      if (sum[64] != sum[63]) begin
        acc_d = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
        acc_d = sum[63:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= 7'd1;
      row_q       <= '0;
      start_q     <= '0;
      k_q         <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        row_count_q <= cfg_data_i;
      end
      if (ctl_i.run_start) begin
        row_q   <= '0;
        start_q <= '0;
      end else if (ctl_i.next_row) begin
        row_q   <= row_q + 7'd1;
        start_q <= ends_rd_q;
      end
      if (ctl_i.end_rd) begin
        k_q <= start_q;
      end else if (ctl_i.issue) begin
        k_q <= k_q + PTR_W'(1);
      end
      v1_q <= ctl_i.issue;
      // drop nonzeros whose column is past the vector
      v2_q <= v1_q && col_ok;
      v3_q <= v2_q;
      if (ctl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      out_q.row  <= row_q[5:0];
      out_q.dot  <= acc_q;
      out_q.last <= stat_o.last_row;
    end
  end

  assign rows = (32'(row_count_q) > MAX_ROWS) ? 7'(MAX_ROWS) : row_count_q;

  always_comb begin
    stat_o.k_lt_end   = k_q < ends_rd_q;
    stat_o.pipe_empty = !(v1_q || v2_q || v3_q);
    stat_o.last_row   = row_q == rows - 7'd1;
    stat_o.rows_zero  = rows == 7'd0;
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/csr_sparse_matvec.sv
// ----------------------------------------------------------------------------
// csr_sparse_matvec: CSR sparse matrix times dense vector
// Loads nonzeros, row ends and vector elements; a run emits one saturating
// Q32.32 dot product per row, with last on the final row.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid_i/in_stall_o   | csm_in_t  (cmd, slot, ...)
//  out     | output    | out_valid_o/out_stall_i | csm_out_t (row, dot, last)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | row_count, 7 bits
//
//  Loads are accepted while the sequencer is idle. After a run is accepted,
//  for each row the sequencer reads the row end, checks the pointer, issues
//  one nonzero per cycle, drains the pipeline through the vector read,
//  multiply and accumulate stages, then emits the result.
//  Reset clears control and sets row_count to 1; memories are not cleared.
//  A stalled result holds the sequencer at the end of the next row.
// ----------------------------------------------------------------------------
module csr_sparse_matvec #(
  parameter int MAX_NONZEROS = 1024,
  parameter int MAX_ROWS     = 64,
  parameter int COLS         = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  csm_pkg::csm_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output csm_pkg::csm_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [6:0]        cfg_data_i
);
  import csm_pkg::*;

  csm_ctl_t  ctl;
  csm_stat_t stat;

  assign cfg_ready_o = 1'b1;

  csm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.cmd),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  csm_datapath #(
    .MAX_NONZEROS (MAX_NONZEROS),
    .MAX_ROWS     (MAX_ROWS),
    .COLS         (COLS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule
